[src/cav_pkg.sv]
// Shared types and constants for the circular array vector.
`default_nettype none
package cav_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int VALUE_W      = 32;
  localparam int KIND_W       = 2;
  localparam int STATUS_W     = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_READ      = 2'd0,
    KIND_OVERWRITE = 2'd1,
    KIND_INSERT    = 2'd2,
    KIND_ERASE     = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    MODE_HOLD      = 3'd0,
    MODE_OVERWRITE = 3'd1,
    MODE_INS_FRONT = 3'd2,
    MODE_INS_BACK  = 3'd3,
    MODE_ERS_FRONT = 3'd4,
    MODE_ERS_BACK  = 3'd5
  } cell_mode_t;

endpackage
`default_nettype wire

[src/cav_cell.sv]
// One element cell: holds a value and takes a neighbor's value on shifts.
`default_nettype none
module cav_cell
  import cav_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int IDX_W    = $clog2(CAPACITY),
  parameter int CNT_W    = $clog2(CAPACITY + 1),
  parameter int PHYS     = 0
) (
  input  wire logic               clk,
  input  wire cell_mode_t         mode,
  input  wire logic [IDX_W-1:0]   front,
  input  wire logic [CNT_W-1:0]   pos,
  input  wire logic [CNT_W-1:0]   held,
  input  wire logic [VALUE_W-1:0] wr_value,
  input  wire logic [VALUE_W-1:0] left_value,
  input  wire logic [VALUE_W-1:0] right_value,
  output logic      [VALUE_W-1:0] value
);

  localparam logic [IDX_W-1:0] P_IDX   = IDX_W'(PHYS);
  localparam logic [IDX_W-1:0] LAST    = IDX_W'(CAPACITY - 1);
  localparam logic [IDX_W:0]   CAP_EXT = (IDX_W + 1)'(CAPACITY);

  logic [IDX_W:0]     diff;
  logic [IDX_W-1:0]   lidx;
  logic [IDX_W-1:0]   lidx_m;
  logic [CNT_W-1:0]   lcnt;
  logic [CNT_W-1:0]   lcnt_m;
  logic [VALUE_W-1:0] value_r;
  logic [VALUE_W-1:0] value_nxt;

  always_comb begin
    diff = {1'b0, P_IDX} - {1'b0, front};
    if (P_IDX < front) begin
      diff = diff + CAP_EXT;
    end
    lidx   = diff[IDX_W-1:0];
    lidx_m = (lidx == LAST) ? '0 : lidx + 1'b1;
    lcnt   = CNT_W'(lidx);
    lcnt_m = CNT_W'(lidx_m);
  end

  always_comb begin
    value_nxt = value_r;
    unique case (mode)
      MODE_OVERWRITE: begin
        if (lcnt == pos) value_nxt = wr_value;
      end
      MODE_INS_FRONT: begin
        if (lcnt_m == pos) value_nxt = wr_value;
        else if (lcnt_m < pos) value_nxt = right_value;
      end
      MODE_INS_BACK: begin
        if (lcnt == pos) value_nxt = wr_value;
        else if ((lcnt > pos) && (lcnt <= held)) value_nxt = left_value;
      end
      MODE_ERS_FRONT: begin
        if ((lcnt != '0) && (lcnt <= pos)) value_nxt = left_value;
      end
      MODE_ERS_BACK: begin
        if ((lcnt >= pos) && (CNT_W'(lcnt + 1'b1) < held)) value_nxt = right_value;
      end
      default: value_nxt = value_r;
    endcase
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value = value_r;

endmodule
`default_nettype wire

[src/circular_array_vector.sv]
// Top level of the circular array vector: request decode, cell row, result register.
//
// Use: each request on the in_ channel reads, overwrites, inserts or erases the
// element at a logical position of a vector of up to CAPACITY 32-bit values.
// Every request yields exactly one result on the out_ channel carrying the read
// value (zero unless a successful read), a status code and the element count.
// The result is registered and is valid in the cycle after the request is
// accepted. Throughput is one request per cycle while out_tready stays high;
// inserts and erases shift the whole row of element cells in parallel as the
// request is accepted, and the front pointer moves when the front side is shifted.
// in_tready is high while the result register is empty or is being drained,
// so a stalled receiver holds the pending result and blocks further requests.
// Reset empties the vector and sets the front pointer to zero; the element
// cells are not cleared, and no successful request reads an unwritten cell.
`default_nettype none
module circular_array_vector
  import cav_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int IDX_W    = $clog2(CAPACITY),
  parameter int CNT_W    = $clog2(CAPACITY + 1),
  parameter int IN_W     = KIND_W + CNT_W + VALUE_W,
  parameter int IN_TD_W  = ((IN_W + 7) / 8) * 8,
  parameter int OUT_W    = VALUE_W + STATUS_W + CNT_W,
  parameter int OUT_TD_W = ((OUT_W + 7) / 8) * 8
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  // Fields from bit 0: kind, position, value.
  input  wire logic [IN_TD_W-1:0]  in_tdata,
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  // Fields from bit 0: read_value, status, count.
  output logic      [OUT_TD_W-1:0] out_tdata
);

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
  localparam logic [IDX_W-1:0] LAST    = IDX_W'(CAPACITY - 1);
  localparam logic [IDX_W:0]   CAP_EXT = (IDX_W + 1)'(CAPACITY);

  logic [IDX_W-1:0]   front_r, front_nxt;
  logic [CNT_W-1:0]   held_r, held_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0] rd_r, rd_nxt;
  status_t            status_r, status_nxt;
  logic [CNT_W-1:0]   count_r;

  logic               accept;
  kind_t              kind;
  logic [CNT_W-1:0]   pos;
  logic [VALUE_W-1:0] wr_value;
  logic [CNT_W-1:0]   half;
  logic [IDX_W:0]     rd_sum;
  logic [IDX_W-1:0]   rd_phys;
  cell_mode_t         mode;
  logic [VALUE_W-1:0] cell_val [CAPACITY];

  assign accept   = in_tvalid && in_tready;
  assign kind     = kind_t'(in_tdata[KIND_W-1:0]);
  assign pos      = in_tdata[KIND_W +: CNT_W];
  assign wr_value = in_tdata[KIND_W + CNT_W +: VALUE_W];
  assign half     = held_r >> 1;

  always_comb begin
    rd_sum = {1'b0, front_r} + {1'b0, pos[IDX_W-1:0]};
    if (rd_sum >= CAP_EXT) begin
      rd_sum = rd_sum - CAP_EXT;
    end
    rd_phys = rd_sum[IDX_W-1:0];
  end

  // Request checks, the read value and the shift mode broadcast to the cells.
  always_comb begin
    status_nxt = ST_OK;
    mode       = MODE_HOLD;
    rd_nxt     = '0;
    if (kind == KIND_INSERT) begin
      priority if (held_r >= CAP_CNT) status_nxt = ST_FULL;
      else if (pos > held_r)          status_nxt = ST_RANGE;
      else                            status_nxt = ST_OK;
    end else begin
      priority if (held_r == '0) status_nxt = ST_EMPTY;
      else if (pos >= held_r)    status_nxt = ST_RANGE;
      else                       status_nxt = ST_OK;
    end
    if (accept && (status_nxt == ST_OK)) begin
      unique case (kind)
        KIND_READ:      rd_nxt = cell_val[rd_phys];
        KIND_OVERWRITE: mode = MODE_OVERWRITE;
        KIND_INSERT:    mode = (pos <= half) ? MODE_INS_FRONT : MODE_INS_BACK;
        KIND_ERASE:     mode = (pos < half) ? MODE_ERS_FRONT : MODE_ERS_BACK;
        default:        mode = MODE_HOLD;
      endcase
    end
  end

  always_comb begin
    front_nxt = front_r;
    held_nxt  = held_r;
    unique case (mode)
      MODE_INS_FRONT: begin
        front_nxt = (front_r == '0) ? LAST : front_r - 1'b1;
        held_nxt  = held_r + 1'b1;
      end
      MODE_INS_BACK: held_nxt = held_r + 1'b1;
      MODE_ERS_FRONT: begin
        front_nxt = (front_r == LAST) ? '0 : front_r + 1'b1;
        held_nxt  = held_r - 1'b1;
      end
      MODE_ERS_BACK: held_nxt = held_r - 1'b1;
      default: begin
        front_nxt = front_r;
        held_nxt  = held_r;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    localparam int LEFT  = (g + CAPACITY - 1) % CAPACITY;
    localparam int RIGHT = (g + 1) % CAPACITY;

    cav_cell #(
      .CAPACITY (CAPACITY),
      .IDX_W    (IDX_W),
      .CNT_W    (CNT_W),
      .PHYS     (g)
    ) u_cell (
      .clk         (clk),
      .mode        (mode),
      .front       (front_r),
      .pos         (pos),
      .held        (held_r),
      .wr_value    (wr_value),
      .left_value  (cell_val[LEFT]),
      .right_value (cell_val[RIGHT]),
      .value       (cell_val[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r     <= '0;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      front_r     <= front_nxt;
      held_r      <= held_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_r     <= rd_nxt;
      status_r <= status_nxt;
      count_r  <= held_nxt;
    end
  end

  assign in_tready  = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TD_W'({count_r, status_r, rd_r});

`ifndef ASSERT_OFF
  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= CAP_CNT)
    else $error("element count exceeds capacity");

  a_held_step: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> (held_r == $past(held_r)) && (front_r == $past(front_r)))
    else $error("state changed without an accepted request");

  a_result_after_request: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_tvalid && (count_r == held_r))
    else $error("result missing or count does not match state");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (status_r == ST_FULL) |-> (count_r == CAP_CNT))
    else $error("full status with a count below capacity");
`endif

endmodule
`default_nettype wire
